// File: hdl/jec_pkg.sv
package jec_pkg;

    localparam int AXIS_WIDTH = 16;
    localparam int TIME_WIDTH = 32;

    localparam int THR_W      = 15;
    localparam int MSEC_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int EVENT_W    = 3;

    // Width used when an axis magnitude is compared with a threshold.
    localparam int MAG_W = AXIS_WIDTH - 1;
    localparam int CMP_W = (MAG_W > THR_W) ? MAG_W : THR_W;

    localparam logic [THR_W-1:0]  ENTER_RESET   = THR_W'(700);
    localparam logic [THR_W-1:0]  RELEASE_RESET = THR_W'(350);
    localparam logic [MSEC_W-1:0] HOLD_RESET    = MSEC_W'(850);
    localparam logic [MSEC_W-1:0] POLL_RESET    = MSEC_W'(20);

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 3'd0,
        EV_HOLD  = 3'd1,
        EV_CLICK = 3'd2,
        EV_RIGHT = 3'd3,
        EV_LEFT  = 3'd4,
        EV_UP    = 3'd5,
        EV_DOWN  = 3'd6
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEVICE_PRESENT = 3'd0,
        REG_ENTER_THR      = 3'd1,
        REG_RELEASE_THR    = 3'd2,
        REG_HOLD_TIME      = 3'd3,
        REG_POLL_INTERVAL  = 3'd4
    } t_reg_idx;

endpackage

// File: hdl/joystick_event_classifier.sv
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ---------------------------------------------
// in        input      i_in_valid / o_in_ready   i_now_ms, i_read_ok, i_axis_x, i_axis_y,
//                                                i_button_level
// out       output     o_out_valid / i_out_ready o_event_code
// cfg       input      i_cfg_we (no handshake)   i_cfg_index, i_cfg_data
//
// Each sample word is captured in the input register and is then classified
// combinationally into the result register; one word is accepted every cycle while the
// output is not stalled. The tracking state updates at the same edge that loads the result.
// Reset is synchronous and active low; it clears the valid flags and the tracking state
// and restores the register defaults. When the output is stalled, the input register
// still accepts a word if it is empty, then holds it until the result register drains.
module joystick_event_classifier
    import jec_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [TIME_WIDTH-1:0]        i_now_ms,
    input  logic                         i_read_ok,
    input  logic signed [AXIS_WIDTH-1:0] i_axis_x,
    input  logic signed [AXIS_WIDTH-1:0] i_axis_y,
    input  logic                         i_button_level,

    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [EVENT_W-1:0]           o_event_code,

    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    // Configuration registers.
    logic              r_device_present;
    logic [THR_W-1:0]  r_enter_thr;
    logic [THR_W-1:0]  r_release_thr;
    logic [MSEC_W-1:0] r_hold_time;
    logic [MSEC_W-1:0] r_poll_interval;

    // Input register.
    logic                         r_in_vld;
    logic [TIME_WIDTH-1:0]        r_now_ms;
    logic                         r_read_ok;
    logic signed [AXIS_WIDTH-1:0] r_axis_x;
    logic signed [AXIS_WIDTH-1:0] r_axis_y;
    logic                         r_button_level;

    // Result register.
    logic   r_out_vld;
    t_event r_out_code;

    // Tracking state and its next values.
    logic [TIME_WIDTH-1:0] r_last_ms,       n_last_ms;
    logic [TIME_WIDTH-1:0] r_press_start,   n_press_start;
    logic                  r_was_pressed,   n_was_pressed;
    logic                  r_hold_reported, n_hold_reported;
    t_event                r_active_dir,    n_active_dir;
    t_event                n_code;

    logic w_adv;
    logic w_fire;

    // Magnitude of a signed axis value; the most negative value saturates to full scale.
    function automatic logic [MAG_W-1:0] axis_mag(input logic signed [AXIS_WIDTH-1:0] v);
        logic [AXIS_WIDTH-1:0] neg;
        neg = -v;
        if (!v[AXIS_WIDTH-1]) begin
            return v[MAG_W-1:0];
        end else if (neg[AXIS_WIDTH-1]) begin
            return {MAG_W{1'b1}};
        end else begin
            return neg[MAG_W-1:0];
        end
    endfunction

    // The result register drains or is empty, so the input register may move forward.
    assign w_adv       = !r_out_vld || i_out_ready;
    assign w_fire      = r_in_vld && w_adv;
    assign o_in_ready  = !r_in_vld || w_adv;
    assign o_out_valid = r_out_vld;
    assign o_event_code = r_out_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_present <= 1'b0;
            r_enter_thr      <= ENTER_RESET;
            r_release_thr    <= RELEASE_RESET;
            r_hold_time      <= HOLD_RESET;
            r_poll_interval  <= POLL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEVICE_PRESENT: r_device_present <= i_cfg_data[0];
                REG_ENTER_THR:      r_enter_thr      <= i_cfg_data[THR_W-1:0];
                REG_RELEASE_THR:    r_release_thr    <= i_cfg_data[THR_W-1:0];
                REG_HOLD_TIME:      r_hold_time      <= i_cfg_data[MSEC_W-1:0];
                REG_POLL_INTERVAL:  r_poll_interval  <= i_cfg_data[MSEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_now_ms       <= i_now_ms;
            r_read_ok      <= i_read_ok;
            r_axis_x       <= i_axis_x;
            r_axis_y       <= i_axis_y;
            r_button_level <= i_button_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_code <= n_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ms       <= '0;
            r_press_start   <= '0;
            r_was_pressed   <= 1'b0;
            r_hold_reported <= 1'b0;
            r_active_dir    <= EV_NONE;
        end else if (w_fire) begin
            r_last_ms       <= n_last_ms;
            r_press_start   <= n_press_start;
            r_was_pressed   <= n_was_pressed;
            r_hold_reported <= n_hold_reported;
            r_active_dir    <= n_active_dir;
        end
    end

    // Classification of the word in the input register.
    always_comb begin
        logic                  pressed;
        logic [TIME_WIDTH-1:0] since_last;
        logic [TIME_WIDTH-1:0] held_for;
        logic [CMP_W-1:0]      mag_x;
        logic [CMP_W-1:0]      mag_y;
        logic [CMP_W-1:0]      enter_thr;
        logic [CMP_W-1:0]      release_thr;
        logic                  x_pos;
        logic                  y_pos;

        n_last_ms       = r_last_ms;
        n_press_start   = r_press_start;
        n_was_pressed   = r_was_pressed;
        n_hold_reported = r_hold_reported;
        n_active_dir    = r_active_dir;
        n_code          = EV_NONE;

        pressed     = !r_button_level;
        since_last  = r_now_ms - r_last_ms;
        mag_x       = CMP_W'(axis_mag(r_axis_x));
        mag_y       = CMP_W'(axis_mag(r_axis_y));
        enter_thr   = CMP_W'(r_enter_thr);
        release_thr = CMP_W'(r_release_thr);
        x_pos       = !r_axis_x[AXIS_WIDTH-1] && (r_axis_x != '0);
        y_pos       = !r_axis_y[AXIS_WIDTH-1] && (r_axis_y != '0);

        // A new press edge restarts the hold timer; below, the restart is undone unless the sample is due and read.
        if (pressed && !r_was_pressed) begin
            n_press_start   = r_now_ms;
            n_hold_reported = 1'b0;
        end
        held_for = r_now_ms - n_press_start;

        if (r_device_present && (since_last >= TIME_WIDTH'(r_poll_interval))) begin
            // A sample in its slot counts as taken even when the read failed.
            n_last_ms = r_now_ms;
            if (!r_read_ok) begin
                n_press_start   = r_press_start;
                n_hold_reported = r_hold_reported;
            end else if (pressed && !n_hold_reported &&
                         (held_for >= TIME_WIDTH'(r_hold_time))) begin
                // Hold fires once per press and skips the direction logic.
                n_hold_reported = 1'b1;
                n_was_pressed   = 1'b1;
                n_code          = EV_HOLD;
            end else if (!pressed && r_was_pressed && !n_hold_reported) begin
                n_was_pressed = 1'b0;
                n_code        = EV_CLICK;
            end else begin
                n_was_pressed = pressed;
                if (r_active_dir != EV_NONE) begin
                    // Latched direction re-arms only once both axes return near center.
                    if ((mag_x <= release_thr) && (mag_y <= release_thr)) begin
                        n_active_dir = EV_NONE;
                    end
                end else if ((mag_x >= enter_thr) || (mag_y >= enter_thr)) begin
                    // The larger axis wins and X takes ties.
                    if (mag_x >= mag_y) begin
                        n_active_dir = x_pos ? EV_RIGHT : EV_LEFT;
                    end else begin
                        n_active_dir = y_pos ? EV_UP : EV_DOWN;
                    end
                    n_code = n_active_dir;
                end
            end
        end else begin
            n_press_start   = r_press_start;
            n_hold_reported = r_hold_reported;
        end
    end

    // With no joystick present every sample must classify as no event.
    a_absent_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !r_device_present) |=> (r_out_code == EV_NONE))
        else $error("event reported while no device is present");

    // A direction event leaves that direction latched.
    a_dir_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (n_code == EV_RIGHT || n_code == EV_LEFT ||
                    n_code == EV_UP || n_code == EV_DOWN))
        |=> (r_active_dir == r_out_code))
        else $error("direction event without latched direction");

    // A hold event marks the press as held and reported.
    a_hold_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (n_code == EV_HOLD)) |=> (r_hold_reported && r_was_pressed))
        else $error("hold event did not update button state");

    // The result register is only overwritten while it drains or is empty.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> (r_out_vld && $stable(r_out_code)))
        else $error("pending result lost under stall");

endmodule
